[rtl/hdrtm_pkg.sv]
// ----------------------------------------------------------------------------
// hdrtm_pkg: shared constants for the HDR tone-map resolve block
// Field widths, default parameters and configuration register indexes.
// ----------------------------------------------------------------------------
package hdrtm_pkg;

  localparam int FRAC_BITS_DEF   = 16;
  localparam int LUT_ENTRIES_DEF = 1024;

  localparam int CHAN_W     = 25;   // signed linear channel
  localparam int GAIN_W     = 24;   // unsigned exposure gain
  localparam int IN_DATA_W  = 80;   // 3*25 + 2 flags, padded to bytes
  localparam int OUT_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_EXPOSURE_GAIN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DITHER_ENABLE = 1'd1;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  // register stages in one lane, input beat to lane code
  function automatic int lane_depth(input int frac_bits);
    return frac_bits + 9;
  endfunction

endpackage

[rtl/hdrtm_lane.sv]
// ----------------------------------------------------------------------------
// hdrtm_lane: one color channel, exposure to sRGB code
// Gain multiply, filmic curve as a pipelined restoring divider, dither add,
// quantize and gamma ROM lookup. Advances as a whole on en.
// ----------------------------------------------------------------------------
module hdrtm_lane #(
  parameter int FracBits   = hdrtm_pkg::FRAC_BITS_DEF,
  parameter int LutEntries = hdrtm_pkg::LUT_ENTRIES_DEF
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [hdrtm_pkg::CHAN_W-1:0] chan,
  input  logic [hdrtm_pkg::GAIN_W-1:0]      gain,
  input  logic signed [FracBits+1:0]        offset,
  output logic [7:0]                        code
);

  localparam int PW     = hdrtm_pkg::CHAN_W + hdrtm_pkg::GAIN_W;
  localparam int XW     = FracBits + 3;
  localparam int SW     = 2 * XW;
  localparam int DW     = 2 * FracBits + 14;
  localparam int QW     = FracBits + 1;
  localparam int OffW   = FracBits + 2;
  localparam int VW     = FracBits + 3;
  localparam int IdxW   = $clog2(LutEntries);
  localparam int MW     = FracBits + IdxW + 1;
  localparam int NStage = FracBits + 1;

  localparam logic [PW:0]     HalfP  = (PW+1)'(1) << (FracBits - 1);
  localparam logic [PW:0]     SatX   = (PW+1)'(8) << FracBits;
  localparam logic [QW-1:0]   OneQ   = QW'(1) << FracBits;
  localparam logic signed [VW-1:0] OneV = VW'(1) << FracBits;
  localparam logic [MW-1:0]   HalfM  = MW'(1) << (FracBits - 1);
  localparam logic [IdxW:0]   LutMax = (IdxW+1)'(LutEntries - 1);

  // code k is reached once (i/N)^5 >= ((2k-1)/510)^11, exact wide integers
  function automatic logic [LutEntries*8-1:0] build_rom();
    logic [255:0] lhs;
    logic [255:0] rhs;
    logic [LutEntries*8-1:0] r;
    int cnt;
    bit stop;
    r   = '0;
    cnt = 0;
    for (int i = 0; i < LutEntries; i++) begin
      lhs = 256'(1);
      for (int j = 0; j < 11; j++) lhs = lhs * 256'(510);
      for (int j = 0; j < 5; j++) lhs = lhs * 256'(i);
      stop = 1'b0;
      while (cnt < 255 && !stop) begin
        rhs = 256'(1);
        for (int j = 0; j < 11; j++) rhs = rhs * 256'(2 * (cnt + 1) - 1);
        for (int j = 0; j < 5; j++) rhs = rhs * 256'(LutEntries - 1);
        if (lhs < rhs) stop = 1'b1;
        else cnt = cnt + 1;
      end
      r[i*8 +: 8] = 8'(cnt);
    end
    return r;
  endfunction

  localparam logic [LutEntries*8-1:0] GammaRom = build_rom();

  // stage 1: gain product
  logic signed [PW-1:0]   p1;
  logic signed [OffW-1:0] off1;
  always_ff @(posedge clk) begin
    if (en) begin
      p1   <= PW'(chan) * PW'($signed({1'b0, gain}));
      off1 <= offset;
    end
  end

  // stage 2: round to Q.F, zero / saturate flags
  logic [PW:0]   xl_c;
  logic          zero_c;
  logic [XW-1:0] x2;
  logic          zero2, sat2;
  logic signed [OffW-1:0] off2;
  assign xl_c   = ({1'b0, p1} + HalfP) >> FracBits;
  assign zero_c = (p1 <= 0) || (xl_c == '0);
  always_ff @(posedge clk) begin
    if (en) begin
      x2    <= xl_c[XW-1:0];
      zero2 <= zero_c;
      sat2  <= !zero_c && (xl_c >= SatX);
      off2  <= off1;
    end
  end

  // stage 3: square
  logic [SW-1:0] sq3;
  logic [XW-1:0] x3;
  logic          zero3, sat3;
  logic signed [OffW-1:0] off3;
  always_ff @(posedge clk) begin
    if (en) begin
      sq3   <= SW'(x2) * SW'(x2);
      x3    <= x2;
      zero3 <= zero2;
      sat3  <= sat2;
      off3  <= off2;
    end
  end

  // stage 4: numerator and denominator of the curve, then divider stages
  logic [DW-1:0] num_c, den_c;
  assign num_c = DW'(sq3) * DW'(251) + ((DW'(x3) * DW'(3)) << FracBits);
  assign den_c = DW'(sq3) * DW'(243) + ((DW'(x3) * DW'(59)) << FracBits)
               + (DW'(14) << (2 * FracBits));

  logic [DW-1:0]   drem [NStage+1];
  logic [DW-1:0]   dden [NStage+1];
  logic [QW-1:0]   dq   [NStage+1];
  logic            dzero[NStage+1];
  logic            dsat [NStage+1];
  logic signed [OffW-1:0] doff [NStage+1];

  always_ff @(posedge clk) begin
    if (en) begin
      drem[0]  <= num_c;
      dden[0]  <= den_c;
      dq[0]    <= '0;
      dzero[0] <= zero3;
      dsat[0]  <= sat3 || (!zero3 && num_c >= den_c);
      doff[0]  <= off3;
    end
  end

  // one quotient bit per stage
  for (genvar g = 0; g < NStage; g++) begin : g_div
    logic [DW:0] t_c;
    logic        ge_c;
    assign t_c  = {drem[g], 1'b0};
    assign ge_c = t_c >= {1'b0, dden[g]};
    always_ff @(posedge clk) begin
      if (en) begin
        drem[g+1]  <= ge_c ? DW'(t_c - {1'b0, dden[g]}) : t_c[DW-1:0];
        dden[g+1]  <= dden[g];
        dq[g+1]    <= {dq[g][QW-2:0], ge_c};
        dzero[g+1] <= dzero[g];
        dsat[g+1]  <= dsat[g];
        doff[g+1]  <= doff[g];
      end
    end
  end

  // stage 5: tone value plus dither
  logic [QW:0]   qr_c;
  logic [QW-1:0] tone_c;
  logic signed [VW-1:0] v5;
  assign qr_c   = {1'b0, dq[NStage]} + (QW+1)'(1);
  assign tone_c = dsat[NStage]  ? OneQ :
                  dzero[NStage] ? '0   : qr_c[QW:1];
  always_ff @(posedge clk) begin
    if (en) v5 <= $signed({2'b00, tone_c}) + VW'(doff[NStage]);
  end

  // stage 6: quantize to table index
  logic [MW-1:0] prod6;
  logic          lo6, hi6;
  always_ff @(posedge clk) begin
    if (en) begin
      prod6 <= MW'(v5[FracBits-1:0]) * MW'(LutMax) + HalfM;
      lo6   <= v5 <= 0;
      hi6   <= v5 >= OneV;
    end
  end

  // stage 7: gamma ROM read
  logic [IdxW:0]   idx_c;
  logic [IdxW-1:0] idx;
  logic [7:0]      code7;
  logic            lo7, hi7;
  assign idx_c = prod6[FracBits +: IdxW+1];
  assign idx   = (idx_c > LutMax) ? LutMax[IdxW-1:0] : idx_c[IdxW-1:0];
  always_ff @(posedge clk) begin
    if (en) begin
      code7 <= GammaRom[idx*8 +: 8];
      lo7   <= lo6;
      hi7   <= hi6;
    end
  end

  // stage 8: clamp ends
  always_ff @(posedge clk) begin
    if (en) code <= lo7 ? 8'd0 : hi7 ? 8'd255 : code7;
  end

endmodule

[rtl/hdrtm_pack.sv]
// ----------------------------------------------------------------------------
// hdrtm_pack: merge lane codes into a BGRA8 output beat
// Output register of the block; holds while the sink stalls.
// ----------------------------------------------------------------------------
module hdrtm_pack (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       vin,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  output logic       m_tvalid,
  output logic [hdrtm_pkg::OUT_DATA_W-1:0] m_tdata
);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) m_tdata <= {hdrtm_pkg::ALPHA_OPAQUE, red, green, blue};
  end

endmodule

[rtl/hdr_tonemap_srgb_resolve_core.sv]
// ----------------------------------------------------------------------------
// hdr_tonemap_srgb_resolve_core: HDR pixel tone-map and sRGB resolve
// Usage:
//   s_* carries one linear pixel per beat (signed Q8.F red/green/blue plus
//   column and row parity); m_* returns one packed BGRA8 word per beat.
//   cfg_we/cfg_index/cfg_data write exposure_gain (0) and dither_enable (1);
//   write only while the pipeline is empty.
//   Throughput: one pixel per clock while the sink accepts, set by the fully
//   pipelined lanes. The long part of each lane is the restoring divider of
//   the filmic curve, one quotient bit per stage, FracBits + 1 stages.
//   Three identical lanes handle red, green and blue side by side; the pack
//   stage merges their codes and is the output register.
//   Reset clears all valid bits and sets gain to 1.0, dither off. The gamma
//   ROM is a constant table, so no fill pass is needed.
//   When the sink stalls the whole pipeline freezes and s_tready drops in
//   the same cycle; bubbles are not squeezed out.
// ----------------------------------------------------------------------------
module hdr_tonemap_srgb_resolve_core #(
  parameter int FracBits   = hdrtm_pkg::FRAC_BITS_DEF,
  parameter int LutEntries = hdrtm_pkg::LUT_ENTRIES_DEF
) (
  input  logic clk,
  input  logic rst,
  // lin_red[24:0], lin_green[49:25], lin_blue[74:50], col_odd[75],
  // row_odd[76], zero pad [79:77]
  input  logic [hdrtm_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // packed_pixel[31:0]
  output logic [hdrtm_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic                             cfg_we,
  input  logic [hdrtm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hdrtm_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int Depth = hdrtm_pkg::lane_depth(FracBits);
  localparam int OffW  = FracBits + 2;
  localparam int CW    = hdrtm_pkg::CHAN_W;
  localparam logic [FracBits:0] OneQ = (FracBits+1)'(1) << FracBits;
  // ordered dither step, round(2^F / 2040)
  localparam int DitherD = ((1 << FracBits) + 1020) / 2040;
  localparam logic signed [OffW-1:0] OffM3 = OffW'(-3 * DitherD);
  localparam logic signed [OffW-1:0] OffM1 = OffW'(-DitherD);
  localparam logic signed [OffW-1:0] OffP1 = OffW'(DitherD);
  localparam logic signed [OffW-1:0] OffP3 = OffW'(3 * DitherD);

  // configuration registers
  logic [hdrtm_pkg::GAIN_W-1:0] exposure_gain;
  logic                         dither_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      exposure_gain <= hdrtm_pkg::GAIN_W'(OneQ);
      dither_enable <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hdrtm_pkg::REG_EXPOSURE_GAIN: exposure_gain <= cfg_data;
        hdrtm_pkg::REG_DITHER_ENABLE: dither_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // global advance: pipeline moves whenever the output slot is free
  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // dither offset from the 2x2 pattern, picked by {row_odd, col_odd}
  logic [1:0]             sel;
  logic signed [OffW-1:0] offset;
  assign sel = {s_tdata[76], s_tdata[75]};
  always_comb begin
    case (sel)
      2'd0:    offset = OffM3;
      2'd1:    offset = OffM1;
      2'd2:    offset = OffP1;
      default: offset = OffP3;
    endcase
    if (!dither_enable) offset = '0;
  end

  // valid bits alongside the lane stages
  logic [Depth-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[Depth-2:0], s_tvalid};
    end
  end

  logic [7:0] code_r, code_g, code_b;

  hdrtm_lane #(.FracBits(FracBits), .LutEntries(LutEntries)) u_lane_r (
    .clk(clk), .en(adv), .chan($signed(s_tdata[CW-1:0])),
    .gain(exposure_gain), .offset(offset), .code(code_r)
  );

  hdrtm_lane #(.FracBits(FracBits), .LutEntries(LutEntries)) u_lane_g (
    .clk(clk), .en(adv), .chan($signed(s_tdata[2*CW-1:CW])),
    .gain(exposure_gain), .offset(offset), .code(code_g)
  );

  hdrtm_lane #(.FracBits(FracBits), .LutEntries(LutEntries)) u_lane_b (
    .clk(clk), .en(adv), .chan($signed(s_tdata[3*CW-1:2*CW])),
    .gain(exposure_gain), .offset(offset), .code(code_b)
  );

  hdrtm_pack u_pack (
    .clk(clk), .rst(rst), .en(adv), .vin(vld[Depth-1]),
    .red(code_r), .green(code_g), .blue(code_b),
    .m_tvalid(m_tvalid), .m_tdata(m_tdata)
  );

  // a valid beat always carries opaque alpha
  a_alpha: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[31:24] == hdrtm_pkg::ALPHA_OPAQUE)
    else $error("output beat without opaque alpha");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (vld == '0) && !m_tvalid)
    else $error("pipeline not empty after reset");

  // a stalled output freezes the valid bits of every stage
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(vld))
    else $error("pipeline moved while output stalled");

endmodule

[dv/tb_hdr_tonemap_srgb_resolve_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hdr_tonemap_srgb_resolve_core: self-checking bench for the tone-map core
// Streams linear HDR pixels through the core under several exposure and
// dither settings, with random gaps and sink stalls, and checks every BGRA8
// output beat against a bit-exact predictor held in a small scoreboard.
// ----------------------------------------------------------------------------
class tonemap_scoreboard;
  bit [23:0] gain;
  bit        dither_on;
  bit [7:0]  gamma_code [1024];
  bit [31:0] pending_px [$];
  int        errors;

  function new();
    bit [191:0] lhs, rhs;
    int cnt;
    gain = 24'd65536;
    dither_on = 1'b0;
    errors = 0;
    cnt = 0;
    // code k is reached once (i/1023)^5 >= ((2k-1)/510)^11, exact integers
    for (int i = 0; i < 1024; i++) begin
      lhs = 192'd1;
      for (int j = 0; j < 11; j++) lhs = lhs * 192'd510;
      for (int j = 0; j < 5; j++) lhs = lhs * i;
      while (cnt < 255) begin
        rhs = 192'd1;
        for (int j = 0; j < 11; j++) rhs = rhs * (2 * (cnt + 1) - 1);
        for (int j = 0; j < 5; j++) rhs = rhs * 192'd1023;
        if (lhs < rhs) break;
        cnt++;
      end
      gamma_code[i] = cnt[7:0];
    end
  endfunction

  // filmic curve in Q1.16, saturating at 1.0
  function longint filmic(bit signed [24:0] chan);
    longint p, x;
    bit [127:0] num, den, q;
    p = longint'(chan) * longint'({1'b0, gain});
    if (p <= 0) return 0;
    x = (p + 32768) >>> 16;
    if (x == 0) return 0;
    if (x >= (65536 << 3)) return 65536;
    num = 251 * x * x + 3 * x * 65536;
    den = 243 * x * x + 59 * x * 65536 + 14 * 65536 * 65536;
    if (num >= den) return 65536;
    q = (num << 17) / den;
    return longint'((q + 1) >> 1);
  endfunction

  function bit [7:0] encode(longint v);
    longint idx;
    if (v <= 0) return 8'd0;
    if (v >= 65536) return 8'd255;
    idx = (v * 1023 + 32768) >>> 16;
    if (idx > 1023) idx = 1023;
    return gamma_code[idx];
  endfunction

  function void note_pixel(bit signed [24:0] r, bit signed [24:0] g,
                           bit signed [24:0] b, bit col, bit row);
    longint ofs;
    ofs = 0;
    if (dither_on) begin
      case ({row, col})
        2'b00: ofs = -96;
        2'b01: ofs = -32;
        2'b10: ofs = 32;
        default: ofs = 96;
      endcase
    end
    pending_px.push_back({8'hFF, encode(filmic(r) + ofs),
                          encode(filmic(g) + ofs), encode(filmic(b) + ofs)});
  endfunction

  function void check_pixel(bit [31:0] got);
    bit [31:0] want;
    if (pending_px.size() == 0) begin
      $display("%0t: unexpected output beat, expected none, actual %h", $time, got);
      errors++;
      return;
    end
    want = pending_px.pop_front();
    if (got !== want) begin
      $display("%0t: pixel mismatch, expected %h, actual %h", $time, want, got);
      errors++;
    end
  endfunction
endclass

module tb_hdr_tonemap_srgb_resolve_core;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic [hdrtm_pkg::IN_DATA_W-1:0]  s_tdata = '0;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [hdrtm_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic                             cfg_we = 1'b0;
  logic [hdrtm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [hdrtm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  tonemap_scoreboard sb = new();
  bit no_idle = 1'b0;   // phases with back-to-back beats on both sides
  int sink_hold = 0;    // cycles the sink still holds tready low

  always #5 clk = ~clk;

  hdr_tonemap_srgb_resolve_core DUT (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // output monitor: beat taken at the edge, new stall drawn per beat
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      sb.check_pixel(m_tdata);
      sink_hold = no_idle ? 0 : $urandom_range(0, 9);
    end
  end

  // sink ready driven on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      m_tready = 1'b0;
    end else if (sink_hold > 0) begin
      m_tready = 1'b0;
      sink_hold--;
    end else begin
      m_tready = 1'b1;
    end
  end

  // one input beat; tvalid only drops if a gap is drawn
  task automatic send_pixel(bit [24:0] r, bit [24:0] g, bit [24:0] b,
                            bit col, bit row);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata = {3'b000, row, col, b, g, r};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    sb.note_pixel(r, g, b, col, row);
    @(negedge clk);
  endtask

  // drain, let the pipe settle, then write one register
  task automatic write_reg(logic [hdrtm_pkg::CFG_IDX_W-1:0] idx,
                           logic [hdrtm_pkg::CFG_DATA_W-1:0] val);
    s_tvalid = 1'b0;
    while (sb.pending_px.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == hdrtm_pkg::REG_EXPOSURE_GAIN) sb.gain = val;
    else sb.dither_on = val[0];
  endtask

  // channel mix: mostly the curve's active range, some full-width noise
  function automatic bit [24:0] rand_chan();
    case ($urandom_range(0, 9))
      0, 1: return 25'($urandom());
      2: return 25'(-$urandom_range(1, 70000));
      8: return 25'($urandom_range(0, 300));
      9: return $urandom_range(0, 1) ? 25'h0FFFFFF : 25'h1000000;
      default: return 25'($urandom_range(0, 1 << 18));
    endcase
  endfunction

  task automatic random_phase(int n);
    for (int k = 0; k < n; k++)
      send_pixel(rand_chan(), rand_chan(), rand_chan(),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: zero, extremes, unity, saturation (x >= 8), tiny values
    send_pixel(25'd0, 25'd0, 25'd0, 0, 0);
    send_pixel(25'h0FFFFFF, 25'h1000000, 25'd65536, 1, 1);
    send_pixel(25'h1FFFFFF, 25'd1, 25'd32768, 0, 1);
    send_pixel(25'd524288, 25'd524287, 25'd600000, 1, 0);
    send_pixel(25'd100, 25'd1000, 25'd10000, 0, 0);
    send_pixel(-25'd65536, 25'd131072, 25'd16384, 1, 1);

    // dither on: zero input raised by positive offsets, every parity
    write_reg(hdrtm_pkg::REG_DITHER_ENABLE, 24'd1);
    for (int s = 0; s < 4; s++) begin
      send_pixel(25'd0, 25'd65536, 25'h0FFFFFF, s[0], s[1]);
      send_pixel(25'd2000, -25'd5, 25'd300000, s[0], s[1]);
    end
    write_reg(hdrtm_pkg::REG_EXPOSURE_GAIN, 24'hFFFFFF);
    send_pixel(25'd1, 25'd2, 25'h1FFFFFF, 1, 1);
    write_reg(hdrtm_pkg::REG_EXPOSURE_GAIN, 24'd0);
    send_pixel(25'h0FFFFFF, 25'd65536, 25'd0, 1, 0);

    // random phases over a sweep of settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: write_reg(hdrtm_pkg::REG_EXPOSURE_GAIN, 24'd65536);
        1: write_reg(hdrtm_pkg::REG_EXPOSURE_GAIN, 24'd0);
        2: write_reg(hdrtm_pkg::REG_EXPOSURE_GAIN, 24'hFFFFFF);
        3: write_reg(hdrtm_pkg::REG_EXPOSURE_GAIN, 24'd1);
        4: write_reg(hdrtm_pkg::REG_EXPOSURE_GAIN, 24'h020000);
        5: write_reg(hdrtm_pkg::REG_EXPOSURE_GAIN, 24'h004000);
        default: write_reg(hdrtm_pkg::REG_EXPOSURE_GAIN, 24'($urandom()));
      endcase
      write_reg(hdrtm_pkg::REG_DITHER_ENABLE, ph[0] ? 24'hFFFFFF : 24'hFFFFFE);
      no_idle = (ph == 3 || ph == 6);
      random_phase(ph == 1 ? 60 : 185);
    end

    s_tvalid = 1'b0;
    while (sb.pending_px.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (sb.errors == 0 && sb.pending_px.size() == 0) begin
      $display("tb_hdr_tonemap_srgb_resolve_core: PASS");
    end else begin
      $display("tb_hdr_tonemap_srgb_resolve_core: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("tb_hdr_tonemap_srgb_resolve_core: FAIL");
    $finish;
  end

endmodule
